FILE: rtl/core/cpms_pkg.sv
package cpms_pkg;

    // Store geometry.
    localparam int MAX_ITEMS = 1024;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Field widths fixed by the stream format.
    localparam int PRICE_W   = 30;
    localparam int CLASS_W   = 2;
    localparam int MASK_W    = 3;
    localparam int SOLD_W    = PRICE_W + 1;

    // Command codes carried in tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic [PRICE_W-1:0] item_price;
        logic [CLASS_W-1:0] front_class;
        logic [CLASS_W-1:0] back_class;
        logic [CLASS_W-1:0] wanted_class;
    } t_req;

    typedef struct packed {
        logic              sold;
        logic [MASK_W-1:0] mask;
        logic [PRICE_W-1:0] price;
    } t_entry;

    // Tags 1 and 2 name their own class; every other code counts as class 3.
    function automatic logic [MASK_W-1:0] class_bit(input logic [CLASS_W-1:0] tag);
        logic [MASK_W-1:0] bits;
        case (tag)
            2'd1:    bits = 3'b001;
            2'd2:    bits = 3'b010;
            default: bits = 3'b100;
        endcase
        return bits;
    endfunction

endpackage

FILE: rtl/core/cpms_scan.sv
module cpms_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  cpms_pkg::t_req              i_req,
    output logic                        o_req_ready,
    output logic                        o_res_valid,
    output logic [cpms_pkg::SOLD_W-1:0] o_res_price,
    input  logic                        i_res_ready
);

    localparam logic [cpms_pkg::CNT_W-1:0] MaxCnt = cpms_pkg::CNT_W'(cpms_pkg::MAX_ITEMS);

    // Item store: price, class mask and sold mark in one word.
    cpms_pkg::t_entry r_mem [cpms_pkg::MAX_ITEMS];
    cpms_pkg::t_entry r_rd_data;

    cpms_pkg::t_state               r_state;
    cpms_pkg::t_state               n_state;
    logic [cpms_pkg::CNT_W-1:0]     r_count;
    logic [cpms_pkg::CNT_W-1:0]     r_addr;
    logic                           r_chk;
    logic [cpms_pkg::IDX_W-1:0]     r_chk_idx;
    logic                           r_found;
    logic [cpms_pkg::IDX_W-1:0]     r_best_idx;
    logic [cpms_pkg::PRICE_W-1:0]   r_best_price;
    logic [cpms_pkg::MASK_W-1:0]    r_best_mask;
    logic [cpms_pkg::MASK_W-1:0]    r_want;

    logic                           mem_we;
    logic [cpms_pkg::IDX_W-1:0]     mem_addr;
    cpms_pkg::t_entry               mem_wdata;
    logic                           load_ok;
    logic                           query_start;
    logic                           issue;
    logic                           hit;
    logic                           full;

    assign full  = (r_count == MaxCnt);
    assign issue = (r_state == cpms_pkg::ST_SCAN) && (r_addr != r_count);
    assign hit   = r_chk && !r_rd_data.sold && (|(r_rd_data.mask & r_want))
                   && (!r_found || (r_rd_data.price < r_best_price));

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = r_addr[cpms_pkg::IDX_W-1:0];
        mem_wdata   = '0;
        load_ok     = 1'b0;
        query_start = 1'b0;
        unique case (r_state)
            cpms_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req.cmd == cpms_pkg::CMD_LOAD) begin
                        if (!full) begin
                            load_ok        = 1'b1;
                            mem_we         = 1'b1;
                            mem_addr       = r_count[cpms_pkg::IDX_W-1:0];
                            mem_wdata.sold = 1'b0;
                            mem_wdata.mask = cpms_pkg::class_bit(i_req.front_class)
                                             | cpms_pkg::class_bit(i_req.back_class);
                            mem_wdata.price = i_req.item_price;
                        end
                    end else begin
                        query_start = 1'b1;
                        n_state     = (r_count == '0) ? cpms_pkg::ST_RESULT
                                                      : cpms_pkg::ST_SCAN;
                    end
                end
            end
            cpms_pkg::ST_SCAN: begin
                if (!issue && !r_chk) begin
                    n_state = r_found ? cpms_pkg::ST_MARK : cpms_pkg::ST_RESULT;
                end
            end
            cpms_pkg::ST_MARK: begin
                mem_we          = 1'b1;
                mem_addr        = r_best_idx;
                mem_wdata.sold  = 1'b1;
                mem_wdata.mask  = r_best_mask;
                mem_wdata.price = r_best_price;
                n_state         = cpms_pkg::ST_RESULT;
            end
            cpms_pkg::ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = cpms_pkg::ST_IDLE;
                end
            end
            default: n_state = cpms_pkg::ST_IDLE;
        endcase
    end

    assign o_res_price = r_found ? {1'b0, r_best_price} : '1;

    // Single-port store, read data registered.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpms_pkg::ST_IDLE;
            r_count <= '0;
            r_addr  <= '0;
            r_chk   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_ok) begin
                r_count <= r_count + 1'b1;
            end
            if (query_start) begin
                r_addr  <= '0;
                r_chk   <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == cpms_pkg::ST_SCAN) begin
                r_chk <= issue;
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_addr[cpms_pkg::IDX_W-1:0];
        if (query_start) begin
            r_want <= cpms_pkg::class_bit(i_req.wanted_class);
        end
        if (hit) begin
            r_best_idx   <= r_chk_idx;
            r_best_price <= r_rd_data.price;
            r_best_mask  <= r_rd_data.mask;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MaxCnt)
        else $error("item count beyond store depth");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == cpms_pkg::ST_SCAN && mem_we))
        else $error("store written during a scan");

    a_load_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_ok |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted load did not advance the count");

    a_chk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> (cpms_pkg::CNT_W'(r_chk_idx) < r_count))
        else $error("scan examined an entry beyond the count");

endmodule

FILE: rtl/core/class_priority_min_select_core.sv
// Cheapest-item selector by class.
//
// Input stream (s_axis): one transfer is either a load or a query, chosen by
// tuser (0 loads, 1 queries). A load appends one item with a price and two
// class tags; a load into a full store is dropped. A query names a class and
// yields exactly one result transfer on m_axis: the price of the cheapest
// unsold item carrying that class (earlier item on a tie), which is then
// marked sold, or all ones (-1) if none matches. Loads yield no result.
//
// Timing: a query reads every stored entry once through the single-port
// item memory, so the wait for its result grows with the item count and
// the memory port is the limit; the marking step is skipped when nothing
// matches. No new transfer is accepted until the result has moved to the
// output register. One result register sits on the output, so the next
// transfer is accepted while a result waits; a further query result is
// held back until the receiver has taken the previous one.
//
// Reset (synchronous, active low) empties the store by clearing the item
// count; sold marks are rewritten on each load, so no clearing pass is run.
// While m_axis_tready is low the pending result is held stable.
module class_priority_min_select_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [29:0] item_price, [31:30] front_class, [33:32] back_class,
    // [35:34] wanted_class, [39:36] zero
    input  logic [39:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [30:0] sold_price (signed), [31] zero
    output logic [31:0] m_axis_tdata
);

    cpms_pkg::t_req                 req;
    logic                           res_valid;
    logic                           res_ready;
    logic [cpms_pkg::SOLD_W-1:0]    res_price;

    logic                           r_out_valid;
    logic [cpms_pkg::SOLD_W-1:0]    r_out_price;

    // Unpack the input transfer into its fields.
    always_comb begin
        req.cmd          = s_axis_tuser;
        req.item_price   = s_axis_tdata[29:0];
        req.front_class  = s_axis_tdata[31:30];
        req.back_class   = s_axis_tdata[33:32];
        req.wanted_class = s_axis_tdata[35:34];
    end

    cpms_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (s_axis_tready),
        .o_res_valid (res_valid),
        .o_res_price (res_price),
        .i_res_ready (res_ready)
    );

    // The output register takes a new result whenever it is empty or its
    // current contents are leaving in this cycle.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_price <= res_price;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_price};

endmodule
